>>> rtl/core/ddsdec_pkg.sv
// Shared types and constants for the DDS RGB stream decoder.
package ddsdec_pkg;

  typedef enum logic [2:0] {
    ST_PIXEL        = 3'd0,
    ST_NOT_DDS      = 3'd1,
    ST_BAD_HEADER   = 3'd2,
    ST_BAD_FORMAT   = 3'd3,
    ST_BAD_BITCOUNT = 3'd4,
    ST_TRUNCATED    = 3'd5
  } status_e;

  typedef struct packed {
    status_e code;
    logic    four_byte;
    logic    has_alpha;
  } hdr_info_t;

  localparam logic [6:0]  HDR_LAST_POS = 7'd127;
  localparam logic [31:0] DDS_MAGIC    = 32'h2053_4444;
  localparam logic [31:0] HDR_SIZE     = 32'd124;
  localparam logic [31:0] PF_SIZE      = 32'd32;
  localparam logic [31:0] PF_RGB       = 32'h0000_0040;
  localparam logic [31:0] PF_ALPHA     = 32'h0000_0001;
  localparam logic [31:0] MASK_R       = 32'h00FF_0000;
  localparam logic [31:0] MASK_G       = 32'h0000_FF00;
  localparam logic [31:0] MASK_B       = 32'h0000_00FF;
  localparam logic [31:0] MASK_A       = 32'hFF00_0000;
  localparam logic [31:0] BITS_24      = 32'd24;
  localparam logic [31:0] BITS_32      = 32'd32;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

endpackage

>>> rtl/core/ddsdec_hdr.sv
// Header field capture and validity check.
module ddsdec_hdr #(
  parameter int unsigned MAX_DIM = 16384,
  parameter int unsigned DIM_W   = $clog2(MAX_DIM + 1)
) (
  input  logic                  clk_i,
  input  logic                  wr_i,
  input  logic [6:0]            pos_i,
  input  logic [7:0]            byte_i,
  output ddsdec_pkg::hdr_info_t info_o,
  output logic [DIM_W-1:0]      width_o,
  output logic [DIM_W-1:0]      height_o
);
  import ddsdec_pkg::*;

  localparam int unsigned NUM_F   = 11;
  localparam int unsigned F_MAGIC = 0;
  localparam int unsigned F_HSIZE = 1;
  localparam int unsigned F_HGT   = 2;
  localparam int unsigned F_WID   = 3;
  localparam int unsigned F_PFSZ  = 4;
  localparam int unsigned F_FLAGS = 5;
  localparam int unsigned F_BITS  = 6;
  localparam int unsigned F_RMASK = 7;
  localparam int unsigned F_GMASK = 8;
  localparam int unsigned F_BMASK = 9;
  localparam int unsigned F_AMASK = 10;
  localparam logic [4:0] FIELD_WORD [NUM_F] =
    '{5'd0, 5'd1, 5'd3, 5'd4, 5'd19, 5'd20, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26};

  logic [31:0] field_q [NUM_F];
  logic [31:0] max_dim;
  logic        dims_ok;
  logic        fmt_ok;
  logic        bits_ok;

  always_ff @(posedge clk_i) begin
    for (int f = 0; f < NUM_F; f++) begin
      if (wr_i && pos_i[6:2] == FIELD_WORD[f]) begin
        field_q[f][pos_i[1:0]*8 +: 8] <= byte_i;
      end
    end
  end

  assign max_dim = 32'(MAX_DIM);
  assign dims_ok = (field_q[F_WID] != '0) && (field_q[F_WID] <= max_dim) &&
                   (field_q[F_HGT] != '0) && (field_q[F_HGT] <= max_dim);
  assign fmt_ok  = ((field_q[F_FLAGS] & PF_RGB) != '0) &&
                   (field_q[F_RMASK] == MASK_R) && (field_q[F_GMASK] == MASK_G) &&
                   (field_q[F_BMASK] == MASK_B);
  assign bits_ok = (field_q[F_BITS] == BITS_24) || (field_q[F_BITS] == BITS_32);

  always_comb begin
    if (field_q[F_MAGIC] != DDS_MAGIC) begin
      info_o.code = ST_NOT_DDS;
    end else if (field_q[F_HSIZE] != HDR_SIZE || field_q[F_PFSZ] != PF_SIZE ||
                 !dims_ok) begin
      info_o.code = ST_BAD_HEADER;
    end else if (!fmt_ok) begin
      info_o.code = ST_BAD_FORMAT;
    end else if (!bits_ok) begin
      info_o.code = ST_BAD_BITCOUNT;
    end else begin
      info_o.code = ST_PIXEL;
    end
    info_o.four_byte = (field_q[F_BITS] == BITS_32);
    info_o.has_alpha = info_o.four_byte && ((field_q[F_FLAGS] & PF_ALPHA) != '0) &&
                       (field_q[F_AMASK] == MASK_A);
  end

  assign width_o  = field_q[F_WID][DIM_W-1:0];
  assign height_o = field_q[F_HGT][DIM_W-1:0];

endmodule

>>> rtl/core/ddsdec_premul.sv
// Alpha premultiply of three color channels, c*a/255 truncated.
module ddsdec_premul (
  input  logic       en_i,
  input  logic [7:0] c0_i,
  input  logic [7:0] c1_i,
  input  logic [7:0] c2_i,
  input  logic [7:0] a_i,
  output logic [7:0] c0_o,
  output logic [7:0] c1_o,
  output logic [7:0] c2_o
);

  function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] p;
    logic [16:0] s;
    p = c * a;
    s = 17'(p) + 17'(p[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  assign c0_o = en_i ? scale(c0_i, a_i) : c0_i;
  assign c1_o = en_i ? scale(c1_i, a_i) : c1_i;
  assign c2_o = en_i ? scale(c2_i, a_i) : c2_i;

endmodule

>>> rtl/core/dds_rgb_stream_decoder.sv
// Top level of the DDS RGB stream decoder: byte stream in, BGRA pixels out.
//
//  channel  | dir | tdata                          | tuser                 | tlast
//  s_axis   | in  | [7:0] data_byte                | -                     | end_of_file
//  m_axis   | out | b,g,r,a,pixel_x,pixel_y (64b)  | has_alpha, status     | last_pixel
//
// One byte per cycle while the output is not stalled; input and result are registered.
// The header takes 128 items; a pixel result follows its last byte (3 or 4 per pixel).
// Reset returns to the header phase; no clearing pass is needed.
// A stalled output holds its result and stops input until that result is taken.
module dds_rgb_stream_decoder #(
  parameter int unsigned MAX_DIM = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [7:0] blue, [15:8] green, [23:16] red,
                                      // [31:24] alpha, [45:32] pixel_x,
                                      // [59:46] pixel_y, [63:60] zero
  output logic [3:0]  m_axis_tuser,   // [0] image_has_alpha, [3:1] status
  output logic        m_axis_tlast    // last_pixel
);
  import ddsdec_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_PIXELS = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_eof_q;
  logic              adv;
  logic              fire;

  logic [1:0]        phase_q, phase_d;
  logic [6:0]        pos_q, pos_d;
  logic [23:0]       pix_q, pix_d;
  logic [1:0]        bip_q, bip_d;
  logic [DIM_W-1:0]  col_q, col_d;
  logic [DIM_W-1:0]  row_q, row_d;

  hdr_info_t         info;
  logic [DIM_W-1:0]  width;
  logic [DIM_W-1:0]  height;
  logic              hdr_wr;

  logic [23:0]       pix_cur;
  logic [7:0]        alpha_in;
  logic [7:0]        pc0, pc1, pc2;
  logic [DIM_W:0]    col_inc;
  logic [DIM_W:0]    row_inc;
  logic              last;
  logic [31:0]       col_ext;
  logic [31:0]       row_ext;

  logic              res_valid;
  logic [63:0]       res_data;
  logic [3:0]        res_user;
  logic              res_last;

  logic              out_valid_q;
  logic [63:0]       out_data_q;
  logic [3:0]        out_user_q;
  logic              out_last_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && adv;
  assign s_axis_tready = !in_valid_q || adv;
  assign hdr_wr        = fire && (phase_q == PH_HEADER);

  ddsdec_hdr #(.MAX_DIM(MAX_DIM), .DIM_W(DIM_W)) u_hdr (
    .clk_i   (clk_i),
    .wr_i    (hdr_wr),
    .pos_i   (pos_q),
    .byte_i  (in_byte_q),
    .info_o  (info),
    .width_o (width),
    .height_o(height)
  );

  always_comb begin
    pix_cur = pix_q;
    if (bip_q != 2'd3) begin
      pix_cur[bip_q*8 +: 8] = in_byte_q;
    end
  end

  assign alpha_in = (bip_q == 2'd3) ? in_byte_q : ALPHA_OPAQUE;

  ddsdec_premul u_premul (
    .en_i(info.has_alpha),
    .c0_i(pix_cur[7:0]),
    .c1_i(pix_cur[15:8]),
    .c2_i(pix_cur[23:16]),
    .a_i (alpha_in),
    .c0_o(pc0),
    .c1_o(pc1),
    .c2_o(pc2)
  );

  assign col_inc = {1'b0, col_q} + 1'b1;
  assign row_inc = {1'b0, row_q} + 1'b1;
  assign last    = (col_inc == {1'b0, width}) && (row_inc == {1'b0, height});
  assign col_ext = 32'(col_q);
  assign row_ext = 32'(row_q);

  always_comb begin
    logic done;
    done      = 1'b0;
    phase_d   = phase_q;
    pos_d     = pos_q;
    pix_d     = pix_q;
    bip_d     = bip_q;
    col_d     = col_q;
    row_d     = row_q;
    res_valid = 1'b0;
    res_data  = '0;
    res_user  = '0;
    res_last  = 1'b0;
    if (fire) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (pos_q == HDR_LAST_POS) begin
            if (info.code != ST_PIXEL) begin
              res_valid = 1'b1;
              res_user  = {info.code, 1'b0};
              phase_d   = PH_SKIP;
            end else if (in_eof_q) begin
              res_valid = 1'b1;
              res_user  = {ST_TRUNCATED, 1'b0};
              phase_d   = PH_SKIP;
            end else begin
              phase_d = PH_PIXELS;
              pix_d   = '0;
              bip_d   = '0;
              col_d   = '0;
              row_d   = '0;
            end
          end else begin
            pos_d = pos_q + 7'd1;
            if (in_eof_q) begin
              res_valid = 1'b1;
              res_user  = {ST_NOT_DDS, 1'b0};
            end
          end
        end
        PH_PIXELS: begin
          done = (bip_q == 2'd3) || (bip_q == 2'd2 && !info.four_byte);
          if (done) begin
            res_valid = 1'b1;
            if (in_eof_q && !last) begin
              res_user = {ST_TRUNCATED, 1'b0};
            end else begin
              res_data = {4'b0, row_ext[13:0], col_ext[13:0],
                          info.has_alpha ? alpha_in : ALPHA_OPAQUE, pc2, pc1, pc0};
              res_user = {ST_PIXEL, info.has_alpha};
              res_last = last;
            end
            pix_d = '0;
            bip_d = '0;
            if (col_inc >= {1'b0, width}) begin
              col_d = '0;
              row_d = row_inc[DIM_W-1:0];
            end else begin
              col_d = col_inc[DIM_W-1:0];
            end
            if (last) begin
              phase_d = PH_SKIP;
            end
          end else begin
            pix_d = pix_cur;
            bip_d = bip_q + 2'd1;
            if (in_eof_q) begin
              res_valid = 1'b1;
              res_user  = {ST_TRUNCATED, 1'b0};
            end
          end
        end
        PH_SKIP: begin
        end
        default: begin
          phase_d = PH_SKIP;
        end
      endcase
      if (in_eof_q) begin
        phase_d = PH_HEADER;
        pos_d   = '0;
        pix_d   = '0;
        bip_d   = '0;
        col_d   = '0;
        row_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_HEADER;
      pos_q       <= '0;
      pix_q       <= '0;
      bip_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_valid_q <= res_valid;
      end
      phase_q <= phase_d;
      pos_q   <= pos_d;
      pix_q   <= pix_d;
      bip_q   <= bip_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_eof_q  <= s_axis_tlast;
    end
    if (adv && res_valid) begin
      out_data_q <= res_data;
      out_user_q <= res_user;
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> rtl/core/ddsdec_checker.sv
// Port-level checks for the DDS RGB stream decoder, bound to the top level.
module ddsdec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import ddsdec_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[3:1] <= ST_TRUNCATED)
    else $error("status code out of range");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3:1] != ST_PIXEL |->
    m_axis_tdata == 64'd0 && !m_axis_tuser[0] && !m_axis_tlast)
    else $error("error item carries pixel data");

  a_last_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[3:1] == ST_PIXEL)
    else $error("last pixel flag on an error item");

endmodule

bind dds_rgb_stream_decoder ddsdec_checker u_ddsdec_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
